// ===== design/flc_pkg.sv =====
// Shared types and fixed constants of the first-seen label compactor.
package flc_pkg;

   localparam int EPOCH_BITS        = 8;
   localparam int COARSE_INDEX_BITS = 10;

   typedef struct packed {
      logic load_req;
      logic probe_next;
      logic load_rsp;
      logic insert;
      logic clr_write;
   } flc_cmd_type;

   typedef struct packed {
      logic hit;
      logic empty;
      logic full;
      logic wrap;
      logic clr_done;
   } flc_sts_type;

endpackage

// ===== design/first_seen_label_compactor_core.sv =====
// Top level of the first-seen label compactor: controller and datapath.
//
//   Channel  Ports                                      Direction
//   req      req_valid/req_ready, master_cell, last     in
//   rsp      rsp_valid/rsp_ready, index, new, ovf, last out
//
// A beat probes from its hashed slot until a slot matches its label or is free, stepping past
// every occupied slot; the hashed slot memory holds at least twice the table size, so probes
// stay short. One beat is processed at a time by the single memory port.
// After reset, and after every 256th list, a clearing pass sweeps every slot of the slot
// memory; no beat is accepted meanwhile.
// A finished result waits in the output register while the next beat is accepted.
module first_seen_label_compactor_core
   import flc_pkg::*;
#(
   parameter int MAX_COARSE = 1024,
   parameter int LABEL_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [LABEL_BITS-1:0]        req_master_cell,
   input  logic                         req_last_face,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [COARSE_INDEX_BITS-1:0] rsp_coarse_index,
   output logic                         rsp_is_new,
   output logic                         rsp_overflow,
   output logic                         rsp_last_out
);

   flc_cmd_type cmd;
   flc_sts_type sts;

   flc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   flc_datapath #(
      .MAX_COARSE (MAX_COARSE),
      .LABEL_BITS (LABEL_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_master_cell  (req_master_cell),
      .req_last_face    (req_last_face),
      .rsp_coarse_index (rsp_coarse_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// ===== design/flc_datapath.sv =====
// Datapath: hashed slot memory, probe address, entry count, list epoch and result register.
module flc_datapath
   import flc_pkg::*;
#(
   parameter int MAX_COARSE = 1024,
   parameter int LABEL_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  flc_cmd_type                  cmd,
   output flc_sts_type                  sts,
   input  logic [LABEL_BITS-1:0]        req_master_cell,
   input  logic                         req_last_face,
   output logic [COARSE_INDEX_BITS-1:0] rsp_coarse_index,
   output logic                         rsp_is_new,
   output logic                         rsp_overflow,
   output logic                         rsp_last_out
);

   localparam int IDX_BITS  = (MAX_COARSE > 1) ? $clog2(MAX_COARSE) : 1;
   localparam int CNT_W     = IDX_BITS + 1;
   localparam int SLOT_BITS = IDX_BITS + 1;
   localparam int SLOTS     = 1 << SLOT_BITS;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COARSE);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_COARSE - 1);

   typedef struct packed {
      logic                  valid;
      logic [EPOCH_BITS-1:0] epoch;
      logic [LABEL_BITS-1:0] label;
      logic [IDX_BITS-1:0]   idx;
   } slot_type;

   slot_type mem [SLOTS];
   slot_type rd_ff;
   slot_type wdata;

   logic [LABEL_BITS-1:0] label_ff;
   logic                  last_ff;
   logic [SLOT_BITS-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [SLOT_BITS-1:0]  hash;
   logic                  live;
   logic [IDX_BITS-1:0]   idx_sel;
   logic [COARSE_INDEX_BITS-1:0] idx_out;
   logic                  mem_we;

   always_comb begin
      hash = '0;
      for (int i = 0; i < LABEL_BITS; i++) begin
         hash[i % SLOT_BITS] = hash[i % SLOT_BITS] ^ req_master_cell[i];
      end
   end

   assign live         = rd_ff.valid && (rd_ff.epoch == epoch_ff);
   assign sts.hit      = live && (rd_ff.label == label_ff);
   assign sts.empty    = !live;
   assign sts.full     = (count_ff == MAX_CNT);
   assign sts.wrap     = last_ff && (&epoch_ff);
   assign sts.clr_done = &addr_ff;

   always_comb begin
      if (sts.hit) begin
         idx_sel = rd_ff.idx;
      end else if (!sts.full) begin
         idx_sel = count_ff[IDX_BITS-1:0];
      end else begin
         idx_sel = LAST_IDX;
      end
   end

   generate
      if (IDX_BITS > COARSE_INDEX_BITS) begin : g_clamp
         assign idx_out = (|idx_sel[IDX_BITS-1:COARSE_INDEX_BITS]) ?
                          {COARSE_INDEX_BITS{1'b1}} : idx_sel[COARSE_INDEX_BITS-1:0];
      end else begin : g_extend
         assign idx_out = COARSE_INDEX_BITS'(idx_sel);
      end
   endgenerate

   always_comb begin
      addr_in  = addr_ff;
      count_in = count_ff;
      epoch_in = epoch_ff;
      if (cmd.load_req) begin
         addr_in = hash;
      end else if (cmd.probe_next || cmd.clr_write) begin
         addr_in = addr_ff + 1'b1;
      end
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.load_rsp && last_ff) begin
         addr_in  = '0;
         count_in = '0;
         epoch_in = epoch_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         count_ff <= '0;
         epoch_ff <= '0;
      end else begin
         addr_ff  <= addr_in;
         count_ff <= count_in;
         epoch_ff <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         label_ff <= req_master_cell;
         last_ff  <= req_last_face;
      end
      if (cmd.load_rsp) begin
         rsp_coarse_index <= idx_out;
         rsp_is_new       <= sts.empty && !sts.full;
         rsp_overflow     <= sts.empty && sts.full;
         rsp_last_out     <= last_ff;
      end
   end

   always_comb begin
      if (cmd.clr_write) begin
         wdata = '0;
      end else begin
         wdata.valid = 1'b1;
         wdata.epoch = epoch_ff;
         wdata.label = label_ff;
         wdata.idx   = count_ff[IDX_BITS-1:0];
      end
   end

   assign mem_we = cmd.insert || cmd.clr_write;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= wdata;
      end
      rd_ff <= mem[addr_ff];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("Entry count has passed the table size.");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !sts.full && sts.empty)
      else $error("Insert issued into a full table or over a live slot.");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.insert && !last_ff |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Insert did not advance the entry count.");
`endif

endmodule

// ===== design/flc_controller.sv =====
// Controller: sequences acceptance, slot probing, result hand-off and the clearing pass.
module flc_controller
   import flc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  flc_sts_type sts,
   output flc_cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_CHECK = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.hit || sts.empty) begin
               if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  cmd.insert   = sts.empty && !sts.full;
                  state_in     = sts.wrap ? ST_CLEAR : ST_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && sts.wrap |=> state_ff == ST_CLEAR)
      else $error("Epoch wrap did not start a clearing pass.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid_ff || rsp_ready)
      else $error("Result register loaded over an untaken beat.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR && !rsp_valid_ff)
      else $error("Reset did not start the clearing pass.");
`endif

endmodule
